/* sv/ctas_pkg.sv */
// ----------------------------------------------------------------------------
// ctas_pkg
// Shared types and constants for the candidate table aggregate/select block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctas_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int LIM_W  = 7;
  localparam int CMP_W  = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_RADIUS    = 2'd1;
  localparam logic [1:0] REG_LIMIT     = 2'd2;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic TBL_EXACT = 1'b0;
  localparam logic TBL_FUZZY = 1'b1;

  typedef struct packed {
    logic [3:0]       threshold;
    logic [1:0]       radius;
    logic [LIM_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] tm;
    logic [7:0]  sup;
    logic [1:0]  mdist;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* sv/ctas_if.sv */
// ----------------------------------------------------------------------------
// ctas_if
// Valid/ready channels for match/finish items and decision items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctas_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] node_id;
  logic [31:0] row_time;
  logic [4:0]  distance;

  modport source (output valid, kind, node_id, row_time, distance, input ready);
  modport sink   (input valid, kind, node_id, row_time, distance, output ready);
endinterface

interface ctas_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] source_node;
  logic        from_exact_table;
  logic [7:0]  best_support;
  logic [1:0]  best_distance;
  logic [15:0] overflow_count;

  modport source (output valid, hit, source_node, from_exact_table, best_support,
                  best_distance, overflow_count, input ready);
  modport sink   (input valid, hit, source_node, from_exact_table, best_support,
                  best_distance, overflow_count, output ready);
endinterface

`default_nettype wire

/* sv/ctas_ram.sv */
// ----------------------------------------------------------------------------
// ctas_ram
// Simple dual-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ctas_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 74,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/ctas_cfg.sv */
// ----------------------------------------------------------------------------
// ctas_cfg
// APB-style register file: support threshold, match radius, table limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ctas_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output ctas_pkg::cfg_t     cfg
);
  import ctas_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= 4'd1;
      cfg_r.radius    <= 2'd2;
      cfg_r.limit     <= LIM_W'(64);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_THRESHOLD: cfg_r.threshold <= pwdata[3:0];
        REG_RADIUS:    cfg_r.radius    <= pwdata[1:0];
        REG_LIMIT:     cfg_r.limit     <= pwdata[LIM_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD: prdata = {28'd0, cfg_r.threshold};
      REG_RADIUS:    prdata = {30'd0, cfg_r.radius};
      REG_LIMIT:     prdata = {{(32-LIM_W){1'b0}}, cfg_r.limit};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/candidate_table_aggregate_select_core.sv */
// ----------------------------------------------------------------------------
// candidate_table_aggregate_select_core
// Aggregates match rows into exact/fuzzy candidate tables and selects a source.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : valid/ready items. kind 0 adds a match row (node_id, row_time,
//            distance); kind 1 finishes the query (node_id = query node).
//   out_if : one decision item per finish item, none for add items.
//   APB    : registers threshold (0x0), radius (0x4), table limit (0x8);
//            write only while the block is idle.
// Each table sits in one synchronous RAM (one entry per cycle read). An add
// item walks the occupied entries of its table looking for the node, each
// entry through a read state and a compare state; dropped rows touch neither
// table. A finish item scans the exact table, then the fuzzy table if the
// exact table had no qualifying candidate, reading and comparing each entry.
// The decision lands in an output register; the block takes new add items
// while it waits there, and a second finish is scanned but its decision
// waits in S_EMIT until the first decision is taken.
// Reset clears counts, overflow tally and control registers; RAM contents are not
// cleared (fill counts mark what is valid), so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module candidate_table_aggregate_select_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ctas_in_if.sink          in_if,
  ctas_out_if.source       out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import ctas_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD_RD, S_ADD_CMP, S_SEL_RD, S_SEL_CMP, S_EMIT
  } state_t;

  cfg_t cfg;

  ctas_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  state_t           state_r;
  logic             tsel_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] exact_cnt_r, fuzzy_cnt_r;
  logic [15:0]      ovf_r;
  logic [31:0]      q_id_r, q_time_r;
  logic [1:0]       q_dist_r;

  logic             best_v_r, best_exact_r;
  entry_t           best_r;

  logic             out_valid_r, out_hit_r, out_exact_r;
  logic [31:0]      out_node_r;
  logic [7:0]       out_sup_r;
  logic [1:0]       out_dist_r;
  logic [15:0]      out_ovf_r;

  // RAM ports
  logic              ex_we, fz_we, we;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t            wdata, ex_rd, fz_rd, rd;
  logic [ENTRY_W-1:0] ex_rd_raw, fz_rd_raw;

  logic [CNT_W-1:0] cur_cnt;
  logic             at_end, full, match, qual, better, take, emit_load;
  entry_t           upd, fresh;

  ctas_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(ENTRY_W)) u_exact_ram (
    .clk, .we(ex_we), .waddr, .wdata(wdata), .raddr, .rdata(ex_rd_raw)
  );
  ctas_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(ENTRY_W)) u_fuzzy_ram (
    .clk, .we(fz_we), .waddr, .wdata(wdata), .raddr, .rdata(fz_rd_raw)
  );

  assign ex_rd   = entry_t'(ex_rd_raw);
  assign fz_rd   = entry_t'(fz_rd_raw);
  assign rd      = (tsel_r == TBL_FUZZY) ? fz_rd : ex_rd;
  assign cur_cnt = (tsel_r == TBL_FUZZY) ? fuzzy_cnt_r : exact_cnt_r;
  assign at_end  = (idx_r == cur_cnt);
  assign raddr   = idx_r[ADDR_W-1:0];
  assign full    = (cur_cnt == CNT_W'(TABLE_ENTRIES)) ||
                   (CMP_W'(cur_cnt) >= CMP_W'(cfg.limit));
  assign match   = (rd.id == q_id_r);

  // Update of an existing entry: saturate support, keep min distance, newest time.
  always_comb begin
    upd       = rd;
    upd.sup   = (rd.sup == 8'hFF) ? rd.sup : rd.sup + 8'd1;
    upd.mdist = (q_dist_r < rd.mdist) ? q_dist_r : rd.mdist;
    upd.tm    = (q_time_r > rd.tm) ? q_time_r : rd.tm;
  end

  always_comb begin
    fresh.id    = q_id_r;
    fresh.tm    = q_time_r;
    fresh.sup   = 8'd1;
    fresh.mdist = q_dist_r;
  end

  // Write back: update on a hit during the walk, else append at the tail if not full.
  always_comb begin
    we    = 1'b0;
    waddr = idx_r[ADDR_W-1:0];
    wdata = fresh;
    if (state_r == S_ADD_CMP && match) begin
      we    = 1'b1;
      wdata = upd;
    end else if (state_r == S_ADD_RD && at_end && !full) begin
      we = 1'b1;
    end
  end
  assign ex_we = we && (tsel_r == TBL_EXACT);
  assign fz_we = we && (tsel_r == TBL_FUZZY);

  // Selection order: support, then distance, then timestamp, then id.
  always_comb begin
    if (rd.sup != best_r.sup)          better = rd.sup > best_r.sup;
    else if (rd.mdist != best_r.mdist) better = rd.mdist < best_r.mdist;
    else if (rd.tm != best_r.tm)       better = rd.tm > best_r.tm;
    else                               better = rd.id < best_r.id;
  end
  assign qual = !match && (rd.sup >= {4'd0, cfg.threshold});
  assign take = (state_r == S_SEL_CMP) && qual && (!best_v_r || better);

  assign emit_load = (state_r == S_EMIT) && (!out_valid_r || out_if.ready);
  assign in_if.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tsel_r      <= TBL_EXACT;
      idx_r       <= '0;
      exact_cnt_r <= '0;
      fuzzy_cnt_r <= '0;
      ovf_r       <= '0;
      best_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready && !emit_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            q_id_r   <= in_if.node_id;
            q_time_r <= in_if.row_time;
            q_dist_r <= in_if.distance[1:0];
            idx_r    <= '0;
            if (in_if.kind == KIND_FINISH) begin
              tsel_r   <= TBL_EXACT;
              best_v_r <= 1'b0;
              state_r  <= S_SEL_RD;
            end else if (in_if.distance == 5'd0) begin
              tsel_r  <= TBL_EXACT;
              state_r <= S_ADD_RD;
            end else if (in_if.distance <= {3'd0, cfg.radius}) begin
              tsel_r  <= TBL_FUZZY;
              state_r <= S_ADD_RD;
            end
          end
        end
        S_ADD_RD: begin
          if (at_end) begin
            // Node not present: append or count as overflow.
            if (full) begin
              if (ovf_r != 16'hFFFF) ovf_r <= ovf_r + 16'd1;
            end else if (tsel_r == TBL_FUZZY) begin
              fuzzy_cnt_r <= fuzzy_cnt_r + CNT_W'(1);
            end else begin
              exact_cnt_r <= exact_cnt_r + CNT_W'(1);
            end
            state_r <= S_IDLE;
          end else begin
            state_r <= S_ADD_CMP;
          end
        end
        S_ADD_CMP: begin
          if (match) begin
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= S_ADD_RD;
          end
        end
        S_SEL_RD: begin
          if (at_end) begin
            // Fall back to the fuzzy table only when exact gave nothing.
            if (tsel_r == TBL_EXACT && !best_v_r) begin
              tsel_r <= TBL_FUZZY;
              idx_r  <= '0;
            end else begin
              state_r <= S_EMIT;
            end
          end else begin
            state_r <= S_SEL_CMP;
          end
        end
        S_SEL_CMP: begin
          if (take) begin
            best_v_r     <= 1'b1;
            best_r       <= rd;
            best_exact_r <= (tsel_r == TBL_EXACT);
          end
          idx_r   <= idx_r + CNT_W'(1);
          state_r <= S_SEL_RD;
        end
        S_EMIT: begin
          if (emit_load) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= best_v_r;
            out_node_r  <= best_v_r ? best_r.id : 32'hFFFF_FFFF;
            out_exact_r <= best_v_r && best_exact_r;
            out_sup_r   <= best_v_r ? best_r.sup : 8'd0;
            out_dist_r  <= best_v_r ? best_r.mdist : 2'd0;
            out_ovf_r   <= ovf_r;
            exact_cnt_r <= '0;
            fuzzy_cnt_r <= '0;
            ovf_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.hit              = out_hit_r;
  assign out_if.source_node      = out_node_r;
  assign out_if.from_exact_table = out_exact_r;
  assign out_if.best_support     = out_sup_r;
  assign out_if.best_distance    = out_dist_r;
  assign out_if.overflow_count   = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    exact_cnt_r <= CNT_W'(TABLE_ENTRIES) && fuzzy_cnt_r <= CNT_W'(TABLE_ENTRIES))
    else $error("table count beyond capacity");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |=> (exact_cnt_r == '0 && fuzzy_cnt_r == '0 && ovf_r == '0))
    else $error("tables not cleared after decision");

  a_no_write_in_select: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEL_RD || state_r == S_SEL_CMP || state_r == S_EMIT) |-> !we)
    else $error("table write during selection");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_CMP || state_r == S_SEL_CMP) |-> idx_r < cur_cnt)
    else $error("scan index past fill count");
`endif

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for candidate_table_aggregate_select_core: drives match
// and finish items with random bursts, predicts each decision from a local
// copy of both candidate tables, and checks every decision field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ctas_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ctas_in_if  in_ch ();
  ctas_out_if out_ch ();

  candidate_table_aggregate_select_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic        hit;
    logic [31:0] node;
    logic        exact;
    logic [7:0]  sup;
    logic [1:0]  mdist;
    logic [15:0] ovf;
  } decision_t;

  // Local copy of the block's configuration and candidate tables.
  logic [3:0]  thr_q;
  logic [1:0]  rad_q;
  logic [6:0]  lim_q;
  entry_t      exact_tbl [TABLE_ENTRIES];
  entry_t      fuzzy_tbl [TABLE_ENTRIES];
  int          exact_n, fuzzy_n;
  int          ovf_q;
  decision_t   pending_decisions[$];

  bit          failed;
  bit          hold_off;      // receiver forced stall, set by a test
  bit          gaps_on;
  longint      cycles;
  int          decisions_seen;
  logic [31:0] id_pool [8];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Timeout guard: far above the slowest correct run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("candidate_table_aggregate_select_core verification failed");
        $finish;
      end
    end
  end

  // Add one row into a table copy; a new node at a full table only counts.
  function automatic void add_row(ref entry_t tbl [TABLE_ENTRIES], ref int n,
                                  input logic [31:0] id, input logic [31:0] t,
                                  input logic [4:0] d);
    int cap;
    cap = (lim_q > TABLE_ENTRIES) ? TABLE_ENTRIES : lim_q;
    for (int i = 0; i < n; i++) begin
      if (tbl[i].id == id) begin
        if (tbl[i].sup != 8'hFF) tbl[i].sup++;
        if (d[1:0] < tbl[i].mdist && d < 5'd4) tbl[i].mdist = d[1:0];
        if (t > tbl[i].tm) tbl[i].tm = t;
        return;
      end
    end
    if (n >= cap) begin
      if (ovf_q < 65535) ovf_q++;
      return;
    end
    tbl[n].id = id;
    tbl[n].tm = t;
    tbl[n].sup = 8'd1;
    tbl[n].mdist = d[1:0];
    n++;
  endfunction

  // Best qualifying entry: support, then distance, then newest, then low id.
  function automatic int pick_best(ref entry_t tbl [TABLE_ENTRIES], input int n,
                                   input logic [31:0] query);
    int best;
    bit better;
    best = -1;
    for (int i = 0; i < n; i++) begin
      if (tbl[i].id == query || tbl[i].sup < thr_q) continue;
      if (best < 0) better = 1;
      else if (tbl[i].sup != tbl[best].sup) better = tbl[i].sup > tbl[best].sup;
      else if (tbl[i].mdist != tbl[best].mdist) better = tbl[i].mdist < tbl[best].mdist;
      else if (tbl[i].tm != tbl[best].tm) better = tbl[i].tm > tbl[best].tm;
      else better = tbl[i].id < tbl[best].id;
      if (better) best = i;
    end
    return best;
  endfunction

  // Advance the table copies by one accepted item; queue a decision on finish.
  function automatic void absorb_item(logic kind, logic [31:0] id, logic [31:0] t,
                                      logic [4:0] d);
    decision_t dec;
    int w;
    if (kind == KIND_ADD) begin
      if (d == 0) add_row(exact_tbl, exact_n, id, t, 5'd0);
      else if (d <= rad_q) add_row(fuzzy_tbl, fuzzy_n, id, t, d);
      return;
    end
    dec = '{hit: 1'b0, node: 32'hFFFF_FFFF, exact: 1'b0, sup: 8'd0, mdist: 2'd0,
            ovf: ovf_q[15:0]};
    w = pick_best(exact_tbl, exact_n, id);
    if (w >= 0) begin
      dec.hit = 1'b1; dec.node = exact_tbl[w].id; dec.exact = 1'b1;
      dec.sup = exact_tbl[w].sup;
    end else begin
      w = pick_best(fuzzy_tbl, fuzzy_n, id);
      if (w >= 0) begin
        dec.hit = 1'b1; dec.node = fuzzy_tbl[w].id;
        dec.sup = fuzzy_tbl[w].sup; dec.mdist = fuzzy_tbl[w].mdist;
      end
    end
    pending_decisions = {pending_decisions, dec};
    exact_n = 0;
    fuzzy_n = 0;
    ovf_q = 0;
  endfunction

  // Receiver: random stall pattern, plus a forced hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else if (!gaps_on) out_ch.ready <= 1'b1;
      else out_ch.ready <= (cycles % 37 < 20) ? ($urandom_range(0, 3) != 0)
                                              : ($urandom_range(0, 3) == 0);
    end
  end

  // Decision checker: compare each accepted decision against the oldest prediction.
  initial begin
    decision_t want;
    decisions_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        decisions_seen++;
        if (pending_decisions.size() == 0) begin
          $error("decision with nothing predicted: node %h", out_ch.source_node);
          failed = 1;
        end else begin
          want = pending_decisions.pop_front();
          if (out_ch.hit !== want.hit) begin
            $error("hit exp %0d got %0d", want.hit, out_ch.hit); failed = 1;
          end
          if (out_ch.source_node !== want.node) begin
            $error("source_node exp %h got %h", want.node, out_ch.source_node);
            failed = 1;
          end
          if (out_ch.from_exact_table !== want.exact) begin
            $error("from_exact_table exp %0d got %0d", want.exact,
                   out_ch.from_exact_table); failed = 1;
          end
          if (out_ch.best_support !== want.sup) begin
            $error("best_support exp %0d got %0d", want.sup, out_ch.best_support);
            failed = 1;
          end
          if (out_ch.best_distance !== want.mdist) begin
            $error("best_distance exp %0d got %0d", want.mdist, out_ch.best_distance);
            failed = 1;
          end
          if (out_ch.overflow_count !== want.ovf) begin
            $error("overflow_count exp %0d got %0d", want.ovf, out_ch.overflow_count);
            failed = 1;
          end
        end
      end
    end
  end

  // Send one item; hold valid until accepted, then fold it into the prediction.
  task automatic send_item(logic kind, logic [31:0] id, logic [31:0] t, logic [4:0] d);
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.node_id  <= id;
    in_ch.row_time <= t;
    in_ch.distance <= d;
    do @(posedge clk); while (!in_ch.ready);
    absorb_item(kind, id, t, d);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic park_sender();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every predicted decision is taken, then let any add drain.
  task automatic drain();
    park_sender();
    while (pending_decisions.size() != 0) @(negedge clk);
    repeat (2 * TABLE_ENTRIES + 10) @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_q = val[3:0];
      REG_RADIUS:    rad_q = val[1:0];
      REG_LIMIT:     lim_q = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [3:0] thr, logic [1:0] rad, logic [6:0] lim);
    drain();
    reg_write(REG_THRESHOLD, {28'd0, thr});
    reg_write(REG_RADIUS, {30'd0, rad});
    reg_write(REG_LIMIT, {25'd0, lim});
  endtask

  // Random row: ids from a small pool so nodes repeat and support builds up.
  task automatic random_row();
    logic [31:0] id;
    logic [4:0]  d;
    id = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, 7)];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: d = 5'd0;
      4, 5, 6:    d = 5'd1;
      7, 8:       d = 5'($urandom_range(2, 3));
      default:    d = 5'($urandom_range(0, 31));
    endcase
    send_item(KIND_ADD, id, $urandom, d);
  endtask

  task automatic random_query(int rows);
    for (int i = 0; i < rows; i++) random_row();
    send_item(KIND_FINISH, ($urandom_range(0, 2) == 0) ? id_pool[$urandom_range(0, 7)]
                                                       : $urandom,
              $urandom, 5'($urandom));
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < 8; i++) id_pool[i] = $urandom;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
  endtask

  // Directed: field extremes, tie-break order, fallback, query skip, overflow.
  task automatic test_directed();
    send_item(KIND_FINISH, 32'h0, 32'h0, 5'd0);                // empty tables miss
    send_item(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
    send_item(KIND_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0);   // tie -> lowest id
    send_item(KIND_FINISH, 32'h1234_5678, 32'hFFFF_FFFF, 5'd31);
    send_item(KIND_ADD, 32'h10, 32'd5, 5'd2);
    send_item(KIND_ADD, 32'h11, 32'd9, 5'd1);
    send_item(KIND_ADD, 32'h10, 32'd2, 5'd1);                  // min dist lowers
    send_item(KIND_ADD, 32'h12, 32'd1, 5'd16);                 // dropped
    send_item(KIND_ADD, 32'h13, 32'd1, 5'd3);                  // dropped at radius 2
    send_item(KIND_ADD, 32'h20, 32'd7, 5'd0);
    send_item(KIND_FINISH, 32'h20, 32'd0, 5'd0);               // skip query -> fuzzy
    send_item(KIND_ADD, 32'h30, 32'd1, 5'd0);
    send_item(KIND_ADD, 32'h31, 32'd8, 5'd0);                  // newer time wins
    send_item(KIND_FINISH, 32'h99, 32'd0, 5'd0);
    set_config(4'd0, 2'd3, 7'd0);                              // threshold 0, limit 0
    send_item(KIND_ADD, 32'h40, 32'd1, 5'd3);
    send_item(KIND_ADD, 32'h41, 32'd1, 5'd0);
    send_item(KIND_FINISH, 32'h0, 32'd0, 5'd0);
    set_config(4'd15, 2'd3, 7'd127);
    send_item(KIND_ADD, 32'h50, 32'd1, 5'd3);
    send_item(KIND_FINISH, 32'h0, 32'd0, 5'd0);
    set_config(4'd2, 2'd0, 7'd1);                              // radius zero, limit 1
    send_item(KIND_ADD, 32'h60, 32'd1, 5'd0);
    send_item(KIND_ADD, 32'h61, 32'd1, 5'd0);                  // overflow
    send_item(KIND_ADD, 32'h60, 32'd4, 5'd0);
    send_item(KIND_ADD, 32'h62, 32'd1, 5'd1);
    send_item(KIND_FINISH, 32'h0, 32'd0, 5'd0);
  endtask

  // Support saturation at 255 with a single node.
  task automatic test_saturation();
    set_config(4'd8, 2'd2, 7'd2);
    for (int i = 0; i < 300; i++) send_item(KIND_ADD, 32'hABCD, i, 5'd0);
    send_item(KIND_FINISH, 32'h0, 32'd0, 5'd0);
  endtask

  // Random queries across several settings, including the extremes.
  task automatic test_random();
    int sent;
    sent = 0;
    gaps_on = 1;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(4'd1, 2'd2, 7'd64);
        1: set_config(4'd2, 2'd1, 7'd4);
        2: set_config(4'd3, 2'd3, 7'd3);
        3: set_config(4'd8, 2'd2, 7'd64);
        4: set_config(4'd1, 2'd0, 7'd1);
        default: set_config(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                            7'($urandom_range(0, 127)));
      endcase
      refresh_pool();
      while (sent < (phase + 1) * 170) begin
        int rows;
        rows = $urandom_range(0, 16);
        random_query(rows);
        sent += rows + 1;
      end
    end
  endtask

  // Receiver holds off while the sender keeps finishing; then sender pauses.
  task automatic test_backpressure();
    set_config(4'd1, 2'd2, 7'd8);
    refresh_pool();
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) random_query(3);
    join
    drain();
    for (int i = 0; i < 4; i++) random_query(5);
  endtask

  initial begin
    failed = 0; hold_off = 0; gaps_on = 0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.kind = KIND_ADD; in_ch.node_id = '0;
    in_ch.row_time = '0; in_ch.distance = '0;
    thr_q = 4'd1; rad_q = 2'd2; lim_q = 7'd64;
    exact_n = 0; fuzzy_n = 0; ovf_q = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_saturation();
    test_random();
    test_backpressure();
    drain();

    if (!failed && pending_decisions.size() == 0) begin
      $display("candidate_table_aggregate_select_core verification clean");
    end else begin
      $display("candidate_table_aggregate_select_core verification failed");
    end
    $finish;
  end
endmodule

/* candidate_table_aggregate_select_core.f */
sv/ctas_pkg.sv
sv/ctas_if.sv
sv/ctas_ram.sv
sv/ctas_cfg.sv
sv/candidate_table_aggregate_select_core.sv
verif/tb.sv
